[rtl/core/modular_exponentiation_core_macros.svh]
// Assertion macros shared by the checker.
`ifndef MODULAR_EXPONENTIATION_CORE_MACROS_SVH
`define MODULAR_EXPONENTIATION_CORE_MACROS_SVH

// Implication checked on every edge outside reset.
`define MEC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define MEC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/mexp_pkg.sv]
package mexp_pkg;
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RED  = 5'b00010,
		ST_MUL  = 5'b00100,
		ST_SQR  = 5'b01000,
		ST_DONE = 5'b10000
	} mexp_state_t;

	localparam logic FUNC_POW = 1'b0;
	localparam logic FUNC_INV = 1'b1;
endpackage

[rtl/core/mexp_if.sv]
interface mexp_in_if #(parameter int WORD_BITS = 64);
	logic                 valid;
	logic                 ready;
	logic                 func;
	logic [WORD_BITS-1:0] base_value;
	logic [WORD_BITS-1:0] exponent_value;
	logic [WORD_BITS-1:0] modulus_value;
	modport source (output valid, func, base_value, exponent_value, modulus_value,
		input ready);
	modport sink (input valid, func, base_value, exponent_value, modulus_value,
		output ready);
endinterface

interface mexp_out_if #(parameter int WORD_BITS = 64);
	logic                 valid;
	logic                 ready;
	logic [WORD_BITS-1:0] residue_out;
	logic                 zero_modulus;
	modport source (output valid, residue_out, zero_modulus, input ready);
	modport sink (input valid, residue_out, zero_modulus, output ready);
endinterface

[rtl/core/mexp_mulmod.sv]
// Shift-add modular multiplier, one multiplier bit per cycle, MSB first.
// Operands must already be below m, m nonzero. Done once all WORD_BITS multiplier bits are scanned.
module mexp_mulmod #(
	parameter int WORD_BITS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WORD_BITS-1:0] x,
	input  logic [WORD_BITS-1:0] y,
	input  logic [WORD_BITS-1:0] m,
	output logic                 done,
	output logic [WORD_BITS-1:0] prod
);
	localparam int CW = $clog2(WORD_BITS + 1);

	logic [WORD_BITS-1:0] acc_q, y_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q;
	logic [WORD_BITS-1:0] dbl, nxt;

	function automatic logic [WORD_BITS-1:0] add_mod(
		input logic [WORD_BITS-1:0] a, input logic [WORD_BITS-1:0] b,
		input logic [WORD_BITS-1:0] md);
		logic [WORD_BITS-1:0] gap;
		gap = md - b;
		return (a >= gap) ? (a - gap) : (a + b);
	endfunction

	always_comb begin
		dbl = add_mod(acc_q, acc_q, m);
		nxt = y_q[WORD_BITS-1] ? add_mod(dbl, x, m) : dbl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WORD_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			y_q   <= y;
		end else if (busy_q) begin
			acc_q <= nxt;
			y_q   <= {y_q[WORD_BITS-2:0], 1'b0};
		end
	end

	assign prod = acc_q;
endmodule

[rtl/core/modular_exponentiation_core.sv]
// Channel | Dir | Beat contents
// in      | in  | func, base_value, exponent_value, modulus_value
// out     | out | residue_out, zero_modulus
//
// One item at a time. Base reduction is a multiply by 1; each exponent bit
// then costs one square and, if set, one multiply, all on the single shared
// shift-add multiplier. Zero modulus skips the multiplier and goes straight
// from accept to the done state.
// arst_n clears control; in.ready is low from accept until the out beat
// is taken, and the out beat holds while out.ready is low.
module modular_exponentiation_core
	import mexp_pkg::*;
#(
	parameter int WORD_BITS = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	mexp_in_if.sink         in,
	mexp_out_if.source      out
);
	mexp_state_t          state_q;
	logic [WORD_BITS-1:0] acc_q, pw_q, exp_q, mod_q;
	logic                 zm_q, wait_q;   // wait_q: multiplier busy
	logic                 mm_start, mm_done;
	logic [WORD_BITS-1:0] mm_x, mm_y, mm_p;

	// Shared multiplier operands depend on the step.
	// Reduction scans the raw base as the multiplier word against 1, so any
	// base comes out below the modulus.
	always_comb begin
		case (state_q)
			ST_MUL:  begin mm_x = acc_q; mm_y = pw_q; end
			ST_SQR:  begin mm_x = pw_q;  mm_y = pw_q; end
			default: begin mm_x = WORD_BITS'(1); mm_y = pw_q; end
		endcase
	end

	assign mm_start = !wait_q && (state_q == ST_RED || state_q == ST_MUL
		|| state_q == ST_SQR);

	mexp_mulmod #(.WORD_BITS(WORD_BITS)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mm_start),
		.x(mm_x), .y(mm_y), .m(mod_q), .done(mm_done), .prod(mm_p)
	);

	assign in.ready         = (state_q == ST_IDLE);
	assign out.valid        = (state_q == ST_DONE);
	assign out.residue_out  = acc_q;
	assign out.zero_modulus = zm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wait_q  <= 1'b0;
		end else begin
			if (mm_start) wait_q <= 1'b1;
			else if (mm_done) wait_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (in.valid) begin
					if (in.modulus_value == '0) state_q <= ST_DONE;
					else state_q <= ST_RED;
				end
				ST_RED: if (mm_done) begin
					if (exp_q == '0) state_q <= ST_DONE;
					else state_q <= exp_q[0] ? ST_MUL : ST_SQR;
				end
				ST_MUL: if (mm_done) state_q <= ST_SQR;
				ST_SQR: if (mm_done) begin
					// exp_q already shifted here
					if (exp_q == '0) state_q <= ST_DONE;
					else state_q <= exp_q[0] ? ST_MUL : ST_SQR;
				end
				ST_DONE: if (out.ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath. Exponent shifts when the square starts so the next bit is ready.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in.valid) begin
				acc_q <= (in.modulus_value == '0) ? '0 : WORD_BITS'(1);
				zm_q  <= (in.modulus_value == '0);
				mod_q <= in.modulus_value;
				pw_q  <= in.base_value;
				exp_q <= (in.func == FUNC_INV) ? in.modulus_value - WORD_BITS'(2)
					: in.exponent_value;
			end
			ST_RED:  if (mm_done) pw_q <= mm_p;
			ST_MUL:  if (mm_done) acc_q <= mm_p;
			ST_SQR: begin
				if (mm_start) exp_q <= exp_q >> 1;
				if (mm_done)  pw_q  <= mm_p;
			end
			default: ;
		endcase
	end
endmodule

[rtl/core/mexp_checker.sv]
`include "modular_exponentiation_core_macros.svh"
module mexp_checker #(
	parameter int WORD_BITS = 64
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic [WORD_BITS-1:0] in_mod,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [WORD_BITS-1:0] out_res,
	input logic                 out_zm
);
	`MEC_ASSERT_IMP(a_excl, clk, arst_n, out_valid, !in_ready, "ready while result pending")
	`MEC_ASSERT_NXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_res), "result dropped")
	`MEC_ASSERT_IMP(a_zero, clk, arst_n, out_valid && out_zm, out_res == '0, "zero modulus nonzero result")
	`MEC_ASSERT_NXT(a_zfast, clk, arst_n, in_valid && in_ready && in_mod == '0, out_valid && out_zm, "zero modulus late")
endmodule

bind modular_exponentiation_core mexp_checker #(.WORD_BITS(WORD_BITS)) u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in.valid), .in_ready(in.ready),
	.in_mod(in.modulus_value), .out_valid(out.valid), .out_ready(out.ready),
	.out_res(out.residue_out), .out_zm(out.zero_modulus)
);

[sim/tb_top.sv]
module tb_top;
	import mexp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WB = 64;
	localparam int LIMIT_CYCLES = 4_000_000;

	typedef struct packed {
		logic          func;
		logic [WB-1:0] base;
		logic [WB-1:0] expo;
		logic [WB-1:0] modulus;
	} mexp_req_t;

	typedef struct packed {
		logic [WB-1:0] residue;
		logic          zero_mod;
	} mexp_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mexp_in_if  #(.WORD_BITS(WB)) in_ch();
	mexp_out_if #(.WORD_BITS(WB)) out_ch();

	modular_exponentiation_core #(.WORD_BITS(WB)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in(in_ch.sink),
		.out(out_ch.source)
	);

	always #10 clk = ~clk;

	// Results still owed by the core, oldest first.
	mexp_rsp_t pending_residues[$];
	int        error_count = 0;
	int        beats_sent = 0;
	int        beats_checked = 0;
	int        inv_beats = 0;
	int        zero_mod_beats = 0;
	int        send_idle_pct = 0;
	int        recv_idle_pct = 0;
	longint    cycle_count = 0;

	// Predictor: (a*b) mod m on the full 128-bit product.
	function automatic logic [WB-1:0] mulmod(logic [WB-1:0] a, logic [WB-1:0] b,
		logic [WB-1:0] m);
		logic [2*WB-1:0] prod;
		prod = {{WB{1'b0}}, a} * {{WB{1'b0}}, b};
		return WB'(prod % {{WB{1'b0}}, m});
	endfunction

	function automatic mexp_rsp_t predict_residue(mexp_req_t r);
		mexp_rsp_t     rsp;
		logic [WB-1:0] b, e, acc;
		rsp = '0;
		if (r.modulus == '0) begin
			rsp.zero_mod = 1'b1;
			return rsp;
		end
		b = r.base;
		e = r.expo;
		if (r.func == FUNC_INV) begin
			b = b % r.modulus;
			e = r.modulus - WB'(2);
		end
		// exponent zero yields 1 unreduced, even for modulus one
		acc = WB'(1);
		while (e != '0) begin
			if (e[0])
				acc = mulmod(acc, b, r.modulus);
			b = mulmod(b, b, r.modulus);
			e = e >> 1;
		end
		rsp.residue = acc;
		return rsp;
	endfunction

	task automatic report_mismatch(string what, logic [WB-1:0] got, logic [WB-1:0] want);
		error_count++;
		$display("mismatch @%0d: %s got %h want %h", cycle_count, what, got, want);
	endtask

	// One beat on the in channel, with a random idle gap in front.
	// valid stays up after a beat until the next gap or the next beat.
	task automatic send_beat(mexp_req_t r);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid          <= 1'b1;
		in_ch.func           <= r.func;
		in_ch.base_value     <= r.base;
		in_ch.exponent_value <= r.expo;
		in_ch.modulus_value  <= r.modulus;
		do @(posedge clk); while (!in_ch.ready);
		pending_residues = {pending_residues, predict_residue(r)};
		beats_sent++;
		if (r.func == FUNC_INV)
			inv_beats++;
		if (r.modulus == '0)
			zero_mod_beats++;
	endtask

	task automatic send_fields(logic f, logic [WB-1:0] b, logic [WB-1:0] e,
		logic [WB-1:0] m);
		mexp_req_t r;
		r.func = f;
		r.base = b;
		r.expo = e;
		r.modulus = m;
		send_beat(r);
	endtask

	function automatic logic [WB-1:0] rand_word();
		return {$urandom(), $urandom()};
	endfunction

	// Small exponents most of the time keep the run short.
	function automatic logic [WB-1:0] rand_expo();
		case ($urandom_range(3))
			0: return rand_word();
			1: return WB'($urandom_range(255));
			default: return WB'($urandom()) >> $urandom_range(31);
		endcase
	endfunction

	// Known primes for the inverse mode, plus random moduli.
	function automatic logic [WB-1:0] rand_modulus(bit for_inv);
		logic [WB-1:0] primes[6] = '{64'd3, 64'd65537, 64'd1000000007,
			64'd2305843009213693951, 64'hFFFFFFFFFFFFFFC5, 64'hFFFFFFFF00000001};
		if (for_inv && $urandom_range(3) != 0)
			return primes[$urandom_range(5)];
		case ($urandom_range(9))
			0: return WB'($urandom_range(3));
			1: return rand_word() | (64'd1 << 63);
			default: return rand_word() >> $urandom_range(63);
		endcase
	endfunction

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (pending_residues.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_corner_cases();
		send_fields(FUNC_POW, 64'd5, 64'd3, 64'd0);            // zero modulus
		send_fields(FUNC_INV, '1, '1, 64'd0);
		send_fields(FUNC_POW, 64'd7, 64'd0, 64'd1);            // exponent zero, modulus one
		send_fields(FUNC_POW, 64'd7, 64'd9, 64'd1);            // modulus one
		send_fields(FUNC_INV, 64'd7, 64'd0, 64'd1);            // inverse, modulus wraps
		send_fields(FUNC_INV, 64'd9, 64'd0, 64'd2);            // inverse, exponent zero
		send_fields(FUNC_POW, '1, '1, '1);                     // all ones
		send_fields(FUNC_POW, '1, 64'd2, 64'hFFFFFFFFFFFFFFC5);
		send_fields(FUNC_POW, 64'd0, 64'd0, 64'd13);
		send_fields(FUNC_POW, 64'd0, 64'd5, 64'd13);
		send_fields(FUNC_POW, 64'd3, 64'd1 << 63, 64'hFFFFFFFFFFFFFFC5);
		send_fields(FUNC_INV, 64'd3, '1, 64'hFFFFFFFFFFFFFFC5);
		send_fields(FUNC_INV, 64'd1000000007 * 3, 64'd0, 64'd1000000007);  // multiple
		send_fields(FUNC_INV, 64'd5, 64'd0, 64'd15);           // non-prime modulus
		send_fields(FUNC_POW, 64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA, '1);
		send_fields(FUNC_POW, 64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555, 64'h8000000000000000);
		// hold off until the core has delivered everything
		wait_drained();
	endtask

	task automatic test_random(int count);
		bit f;
		for (int i = 0; i < count; i++) begin
			f = $urandom_range(3) == 0;
			send_fields(f, rand_word() >> $urandom_range(3), rand_expo(), rand_modulus(f));
		end
	endtask

	// Result side: random stalls, each beat checked against the oldest prediction.
	always @(posedge clk) begin
		mexp_rsp_t want;
		cycle_count <= cycle_count + 1;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			beats_checked++;
			if (pending_residues.size() == 0) begin
				report_mismatch("unexpected beat", out_ch.residue_out, '0);
			end else begin
				want = pending_residues.pop_front();
				if (out_ch.residue_out !== want.residue)
					report_mismatch("residue_out", out_ch.residue_out, want.residue);
				if (out_ch.zero_modulus !== want.zero_mod)
					report_mismatch("zero_modulus", WB'(out_ch.zero_modulus),
						WB'(want.zero_mod));
			end
		end
		out_ch.ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		in_ch.valid          = 1'b0;
		in_ch.func           = FUNC_POW;
		in_ch.base_value     = '0;
		in_ch.exponent_value = '0;
		in_ch.modulus_value  = '0;
		out_ch.ready         = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 36;
		recv_idle_pct = 56;
		test_corner_cases();
		test_random(28);
		send_idle_pct = 56;
		recv_idle_pct = 36;
		test_random(28);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(28);

		wait_drained();
		repeat (200) @(posedge clk);
		$display("%0d beats sent, %0d checked: %0d inverse, %0d zero modulus",
			beats_sent, beats_checked, inv_beats, zero_mod_beats);
		$display("corner cases, random powers and Fermat inverses, three idle mixes");
		if (error_count == 0 && pending_residues.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

[files.f]
+incdir+rtl/core
rtl/core/mexp_pkg.sv
rtl/core/mexp_if.sv
rtl/core/mexp_mulmod.sv
rtl/core/modular_exponentiation_core.sv
rtl/core/mexp_checker.sv
sim/tb_top.sv
